// File: sv/assert_macros.svh
// Assertion macros shared by the matcher RTL.
// Needs aclk and aresetn in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ldsbm_pkg.sv
// Shared types, constants and helpers of the layered DFA builder/matcher.
// No dependencies; the ctrl, datapath and top-level files import this package.
package ldsbm_pkg;

    localparam int MAX_LAYERS  = 16;
    localparam int MAX_STATES  = 256;
    localparam int MAX_SYMBOLS = 16;
    localparam int NUM_CONST   = 2;   // states 0 (reject all) and 1 (accept all)

    localparam int LAYER_W    = 4;
    localparam int STATE_W    = 8;
    localparam int SYM_W      = 4;
    localparam int COUNT_W    = 9;
    localparam int POS_W      = 5;
    localparam int NL_W       = 5;
    localparam int ERR_W      = 2;
    localparam int STORE_AW   = LAYER_W + STATE_W + SYM_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_LAYERS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_START_STATE = 1'b1;

    localparam logic OP_ADD     = 1'b0;
    localparam logic OP_MATCH   = 1'b1;
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_MATCH = 1'b1;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    localparam logic [COUNT_W-1:0] CONST_STATES = COUNT_W'(NUM_CONST);

    typedef struct packed {
        logic               op;
        logic [LAYER_W-1:0] layer;
        logic [STATE_W-1:0] next_state;
        logic [SYM_W-1:0]   symbol;
        logic               last;
    } in_t;

    typedef struct packed {
        logic               kind;
        logic [STATE_W-1:0] state_id;
        logic               accepted;
        logic [ERR_W-1:0]   error;
    } out_t;

    typedef struct packed {
        logic load;    // request accepted: latch it, issue table reads
        logic exec;    // evaluate the latched request
        logic sweep;   // copy one staged entry into the transition store
        logic push;    // move the pending result into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic result;      // latched request produces a result
        logic commit;      // latched request allocates a new state
        logic sweep_last;  // final staged entry is being written
        logic out_free;    // output register can take a result
    } dp_sts_t;

    // Zero acts as one layer; anything above the maximum saturates.
    function automatic logic [NL_W-1:0] eff_layers(input logic [NL_W-1:0] nl);
        logic [NL_W-1:0] r;
        r = nl;
        if (nl == '0) begin
            r = NL_W'(1);
        end else if (nl > NL_W'(MAX_LAYERS)) begin
            r = NL_W'(MAX_LAYERS);
        end
        return r;
    endfunction

endpackage

// File: sv/ldsbm_ctrl.sv
// Sequencing FSM of the layered DFA builder/matcher.
// Depends on ldsbm_pkg and assert_macros.svh; drives the datapath by dp_cmd_t.
`include "assert_macros.svh"

module ldsbm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output ldsbm_pkg::dp_cmd_t cmd,
    input  ldsbm_pkg::dp_sts_t sts
);
    import ldsbm_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_PUSH  = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (sts.commit) begin
                    state_next = ST_SWEEP;
                end else if (sts.result) begin
                    state_next = ST_PUSH;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                // hold until the output register frees up
                if (sts.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `ASSERT_IMPL(a_sweep_after_exec, state_reg == ST_SWEEP, $past(state_reg) == ST_EXEC || $past(state_reg) == ST_SWEEP, "sweep entered without an evaluation")
    `ASSERT_NEXT(a_load_then_exec, cmd.load, state_reg == ST_EXEC, "accepted request not evaluated next cycle")

endmodule

// File: sv/ldsbm_dp.sv
// Datapath of the layered DFA builder/matcher: transition store, per-layer
// state counts, add and match state, staging buffer and output register.
// Depends on ldsbm_pkg and assert_macros.svh; commanded by ldsbm_ctrl.
`include "assert_macros.svh"

module ldsbm_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ldsbm_pkg::dp_cmd_t          cmd,
    output ldsbm_pkg::dp_sts_t          sts,
    input  ldsbm_pkg::in_t              s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ldsbm_pkg::out_t             m_data,
    input  logic [ldsbm_pkg::NL_W-1:0]    num_layers,
    input  logic [ldsbm_pkg::STATE_W-1:0] start_state
);
    import ldsbm_pkg::*;

    // Transition store, undefined until written.
    logic [STATE_W-1:0]  store_mem [0:(1<<STORE_AW)-1];
    logic [STATE_W-1:0]  store_rd_reg;
    logic [STORE_AW-1:0] store_raddr, store_waddr;
    logic                store_we;

    // Per-layer state counts; an entry without its valid bit reads as two.
    logic [COUNT_W-1:0]    cnt_mem [0:MAX_LAYERS-1];
    logic [MAX_LAYERS-1:0] cnt_vld_reg, cnt_vld_next;
    logic [COUNT_W-1:0]    cnt_a_reg, cnt_b_reg;
    logic                  cnt_vld_a_reg, cnt_vld_b_reg;
    logic [LAYER_W-1:0]    cnt_addr_a, cnt_addr_b;
    logic                  cnt_we;
    logic [COUNT_W-1:0]    count_a, count_b;

    logic [STATE_W-1:0] staging [0:MAX_SYMBOLS-1];

    in_t                item_reg;
    logic [LAYER_W-1:0] match_layer_reg, match_layer_next;
    logic [STATE_W-1:0] match_state_reg, match_state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [STATE_W-1:0] first_reg, first_next;
    logic               same_reg, same_next;
    logic               err_reg, err_next;
    logic [LAYER_W-1:0] add_layer_reg, add_layer_next;

    logic [LAYER_W-1:0] commit_layer_reg;
    logic [STATE_W-1:0] commit_id_reg;
    logic [SYM_W-1:0]   sweep_idx_reg, sweep_idx_next;
    logic [POS_W-1:0]   sweep_cnt_reg;
    out_t               res_reg;
    out_t               m_data_reg;
    logic               m_valid_reg, m_valid_next;

    // load-time address selection
    logic [LAYER_W-1:0] lay_in;
    logic [STATE_W-1:0] cur_in;

    // evaluation
    logic [NL_W-1:0]    n_eff;
    logic [STATE_W-1:0] cur, nxt;
    logic               match_done;
    logic               add_first;
    logic [LAYER_W-1:0] lay;
    logic [STATE_W-1:0] fst;
    logic               same, err_acc, layer_bad, entry_bad;
    logic [COUNT_W-1:0] bound;
    logic [POS_W-1:0]   pos_inc, ent_cnt;
    logic               do_commit;
    out_t               res_next;

    assign lay_in      = (pos_reg == '0) ? s_data.layer : add_layer_reg;
    assign cnt_addr_a  = (s_data.op == OP_MATCH) ? match_layer_reg : lay_in;
    assign cnt_addr_b  = lay_in + LAYER_W'(1);
    assign cur_in      = (match_layer_reg == '0) ? start_state : match_state_reg;
    assign store_raddr = {match_layer_reg, cur_in, s_data.symbol};

    assign store_we    = cmd.sweep;
    assign store_waddr = {commit_layer_reg, commit_id_reg, sweep_idx_reg};

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[store_waddr] <= staging[sweep_idx_reg];
        end
        if (cmd.load) begin
            store_rd_reg <= store_mem[store_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[lay] <= count_a + COUNT_W'(1);
        end
        if (cmd.load) begin
            cnt_a_reg     <= cnt_mem[cnt_addr_a];
            cnt_b_reg     <= cnt_mem[cnt_addr_b];
            cnt_vld_a_reg <= cnt_vld_reg[cnt_addr_a];
            cnt_vld_b_reg <= cnt_vld_reg[cnt_addr_b];
        end
    end

    assign count_a = cnt_vld_a_reg ? cnt_a_reg : CONST_STATES;
    assign count_b = cnt_vld_b_reg ? cnt_b_reg : CONST_STATES;
    assign n_eff   = eff_layers(num_layers);

    always_comb begin
        // match step
        cur = (match_layer_reg == '0) ? start_state : match_state_reg;
        if (cur < STATE_W'(NUM_CONST)) begin
            nxt = cur;
        end else if ({1'b0, cur} >= count_a) begin
            nxt = '0;
        end else begin
            nxt = store_rd_reg;
        end
        match_done = ({1'b0, match_layer_reg} + NL_W'(1)) >= n_eff;

        // add entry
        add_first = (pos_reg == '0);
        lay       = add_first ? item_reg.layer : add_layer_reg;
        fst       = add_first ? item_reg.next_state : first_reg;
        same      = add_first | (same_reg & (item_reg.next_state == first_reg));
        err_acc   = add_first ? 1'b0 : err_reg;
        layer_bad = {1'b0, lay} >= n_eff;
        bound     = (({1'b0, lay} + NL_W'(1)) >= n_eff) ? CONST_STATES : count_b;
        entry_bad = {1'b0, item_reg.next_state} >= bound;
        pos_inc   = (pos_reg <= POS_W'(MAX_SYMBOLS)) ? pos_reg + POS_W'(1) : pos_reg;
        ent_cnt   = (pos_inc > POS_W'(MAX_SYMBOLS)) ? POS_W'(MAX_SYMBOLS) : pos_inc;

        do_commit = 1'b0;
        res_next  = '0;
        if (item_reg.op == OP_MATCH) begin
            res_next.kind     = KIND_MATCH;
            res_next.accepted = (nxt != '0);
        end else begin
            res_next.kind = KIND_ADD;
            if (same && fst < STATE_W'(NUM_CONST)) begin
                res_next.state_id = fst;
            end else if (layer_bad) begin
                res_next.error = ERR_RANGE;
            end else if (count_a >= COUNT_W'(MAX_STATES)) begin
                res_next.error = ERR_FULL;
            end else if (err_acc | entry_bad) begin
                res_next.error = ERR_RANGE;
            end else begin
                res_next.state_id = count_a[STATE_W-1:0];
                do_commit         = 1'b1;
            end
        end
    end

    assign sts.result     = (item_reg.op == OP_MATCH) ? match_done : item_reg.last;
    assign sts.commit     = (item_reg.op == OP_ADD) & item_reg.last & do_commit;
    assign sts.sweep_last = ({1'b0, sweep_idx_reg} + POS_W'(1)) == sweep_cnt_reg;
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign cnt_we = cmd.exec & sts.commit;

    always_comb begin
        match_layer_next = match_layer_reg;
        match_state_next = match_state_reg;
        pos_next         = pos_reg;
        first_next       = first_reg;
        same_next        = same_reg;
        err_next         = err_reg;
        add_layer_next   = add_layer_reg;
        cnt_vld_next     = cnt_vld_reg;
        sweep_idx_next   = sweep_idx_reg;
        m_valid_next     = m_valid_reg & !m_ready;

        if (cmd.exec) begin
            if (item_reg.op == OP_MATCH) begin
                if (match_done) begin
                    match_layer_next = '0;
                    match_state_next = '0;
                end else begin
                    match_layer_next = match_layer_reg + LAYER_W'(1);
                    match_state_next = nxt;
                end
            end else begin
                add_layer_next = lay;
                first_next     = fst;
                if (item_reg.last) begin
                    pos_next  = '0;
                    same_next = 1'b1;
                    err_next  = 1'b0;
                end else begin
                    pos_next  = pos_inc;
                    same_next = same;
                    err_next  = err_acc | layer_bad | entry_bad;
                end
                if (cnt_we) begin
                    cnt_vld_next[lay] = 1'b1;
                end
            end
            sweep_idx_next = '0;
        end
        if (cmd.sweep) begin
            sweep_idx_next = sweep_idx_reg + SYM_W'(1);
        end
        if (cmd.push) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_layer_reg <= '0;
            match_state_reg <= '0;
            pos_reg         <= '0;
            first_reg       <= '0;
            same_reg        <= 1'b1;
            err_reg         <= 1'b0;
            add_layer_reg   <= '0;
            cnt_vld_reg     <= '0;
            sweep_idx_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            match_layer_reg <= match_layer_next;
            match_state_reg <= match_state_next;
            pos_reg         <= pos_next;
            first_reg       <= first_next;
            same_reg        <= same_next;
            err_reg         <= err_next;
            add_layer_reg   <= add_layer_next;
            cnt_vld_reg     <= cnt_vld_next;
            sweep_idx_reg   <= sweep_idx_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.exec) begin
            res_reg          <= res_next;
            commit_layer_reg <= lay;
            commit_id_reg    <= count_a[STATE_W-1:0];
            sweep_cnt_reg    <= ent_cnt;
            // drop entries past the symbol count
            if (item_reg.op == OP_ADD && pos_reg < POS_W'(MAX_SYMBOLS)) begin
                staging[pos_reg[SYM_W-1:0]] <= item_reg.next_state;
            end
        end
        if (cmd.push) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_IMPL(a_push_when_free, cmd.push, !m_valid_reg || m_ready, "result pushed over a pending one")
    `ASSERT_IMPL(a_commit_has_room, cmd.exec && sts.commit, count_a < COUNT_W'(MAX_STATES), "state allocated in a full layer")
    `ASSERT_IMPL(a_valid_from_push, $rose(m_valid_reg), $past(cmd.push), "output valid without a push")

endmodule

// File: sv/layered_dfa_state_builder_matcher_unit.sv
// Layered DFA builder/matcher: one request at a time. Each request is accepted with its table
// reads and then evaluated; a result then waits in the push state until the output register is free.
// Storing a new state adds a write sweep of its entries (1..16) into the transition store.
// The store read of each match symbol depends on the state found for the previous symbol.
// Synchronous active-low reset: layer counts read as 2 through valid bits, match and add
// state clear; the transition store is not cleared and needs no reset pass.
module layered_dfa_state_builder_matcher_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ldsbm_pkg::in_t                   s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ldsbm_pkg::out_t                  m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ldsbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ldsbm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ldsbm_pkg::*;

    logic [NL_W-1:0]    num_layers_reg;
    logic [STATE_W-1:0] start_state_reg;
    dp_cmd_t            cmd;
    dp_sts_t            sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_layers_reg  <= NL_W'(1);
            start_state_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_NUM_LAYERS:  num_layers_reg  <= cfg_data[NL_W-1:0];
                REG_START_STATE: start_state_reg <= cfg_data[STATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ldsbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    ldsbm_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .num_layers  (num_layers_reg),
        .start_state (start_state_reg)
    );

endmodule
